>>> design/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared types and constants for the reservation station scheduler
// ----------------------------------------------------------------------------
package rss_pkg;

    // default pool size
    localparam int DEF_NUM_STATIONS = 8;

    // fixed field widths
    localparam int MASK_W     = 8;
    localparam int STA_W      = 3;
    localparam int UNITS_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ORDER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_UNITS = 1'd1;

    // operation codes
    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_ISSUE,
        DP_RETIRE,
        DP_WBACK,
        DP_DISPATCH,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_end;
        logic is_tick;
    } dp_status_t;

endpackage

>>> design/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// sequencer: picks the datapath operation for each cycle of a word
// ----------------------------------------------------------------------------
module rss_ctrl
    import rss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SELECT,
        S_ISSUE,
        S_RETIRE,
        S_WBACK,
        S_DISPATCH,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                state_next = status.is_tick ? S_RETIRE : S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.op     = DP_ISSUE;
                state_next = S_EMIT;
            end
            S_RETIRE:
            begin
                cmd.op = DP_RETIRE;
                if (status.walk_end)
                    state_next = S_WBACK;
            end
            S_WBACK:
            begin
                cmd.op = DP_WBACK;
                if (status.walk_end)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.op = DP_DISPATCH;
                if (status.walk_end)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op     = DP_EMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> design/rss_datapath.sv
// ----------------------------------------------------------------------------
// rss_datapath
// station lists, counts, list walker and result registers
// ----------------------------------------------------------------------------
module rss_datapath
    import rss_pkg::*;
#(
    parameter int NUM_STATIONS = DEF_NUM_STATIONS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  operation,
    input  logic [MASK_W-1:0]     ready_mask,
    input  logic [MASK_W-1:0]     exec_done_mask,
    input  logic [MASK_W-1:0]     write_done_mask,
    output logic                  done,
    output logic                  issue_accepted,
    output logic [STA_W-1:0]      issue_station,
    output logic [MASK_W-1:0]     retired_mask,
    output logic [MASK_W-1:0]     start_write_mask,
    output logic [MASK_W-1:0]     start_exec_mask,
    output logic                  unit_idle
);

    localparam int IDX_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam int CNT_W = $clog2(NUM_STATIONS + 1);
    localparam int SUM_W = (CNT_W + 1 > UNITS_W) ? CNT_W + 1 : UNITS_W;
    localparam logic [SUM_W-1:0] N_SUM    = SUM_W'(NUM_STATIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STATIONS - 1);

    // configuration
    logic               in_order_reg;
    logic [UNITS_W-1:0] units_reg;

    // latched word
    logic              op_reg;
    logic [MASK_W-1:0] ready_reg;
    logic [MASK_W-1:0] xdone_reg;
    logic [MASK_W-1:0] wdone_reg;

    // lists, idle is a circular queue
    logic [IDX_W-1:0] idle_list_reg   [NUM_STATIONS];
    logic [IDX_W-1:0] issued_list_reg [NUM_STATIONS];
    logic [IDX_W-1:0] exec_list_reg   [NUM_STATIONS];
    logic [IDX_W-1:0] write_list_reg  [NUM_STATIONS];
    logic [IDX_W-1:0] idle_head_reg;
    logic [CNT_W-1:0] idle_cnt_reg;
    logic [CNT_W-1:0] issued_cnt_reg;
    logic [CNT_W-1:0] exec_cnt_reg;
    logic [CNT_W-1:0] write_cnt_reg;

    // walker
    logic [CNT_W-1:0] walk_i_reg;
    logic [CNT_W-1:0] walk_k_reg;
    logic             stop_reg;

    // result
    logic              done_reg;
    logic              acc_reg;
    logic [STA_W-1:0]  st_reg;
    logic [MASK_W-1:0] ret_reg;
    logic [MASK_W-1:0] sw_reg;
    logic [MASK_W-1:0] sx_reg;
    logic              unit_idle_reg;

    logic [IDX_W-1:0]  cur_s;
    logic [CNT_W-1:0]  cur_n;
    logic [STA_W-1:0]  s_low;
    logic              in_mask;
    logic [MASK_W-1:0] s_bit;
    logic              units_free;
    logic              take;
    logic              walk_end;
    logic              walking;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  idle_tail;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic              have_idle;

    assign rd_idx = walk_i_reg[IDX_W-1:0];
    assign wr_idx = walk_k_reg[IDX_W-1:0];

    always_comb
    begin
        case (cmd.op)
            DP_RETIRE:
            begin
                cur_s = write_list_reg[rd_idx];
                cur_n = write_cnt_reg;
            end
            DP_WBACK:
            begin
                cur_s = exec_list_reg[rd_idx];
                cur_n = exec_cnt_reg;
            end
            default:
            begin
                cur_s = issued_list_reg[rd_idx];
                cur_n = issued_cnt_reg;
            end
        endcase
    end

    // stations past the mask width never match and never show
    assign s_low   = STA_W'(cur_s);
    assign in_mask = (SUM_W'(cur_s) < SUM_W'(MASK_W));
    assign s_bit   = in_mask ? (MASK_W'(1) << s_low) : '0;

    assign units_free = (SUM_W'(exec_cnt_reg) + SUM_W'(write_cnt_reg)) < SUM_W'(units_reg);

    always_comb
    begin
        case (cmd.op)
            DP_RETIRE:   take = |(wdone_reg & s_bit);
            DP_WBACK:    take = !stop_reg && |(xdone_reg & s_bit);
            DP_DISPATCH: take = !stop_reg && |(ready_reg & s_bit) && units_free;
            default:     take = 1'b0;
        endcase
    end

    assign walking  = (cmd.op == DP_RETIRE) || (cmd.op == DP_WBACK) ||
                      (cmd.op == DP_DISPATCH);
    assign walk_end = (walk_i_reg == cur_n);

    assign tail_sum  = SUM_W'(idle_head_reg) + SUM_W'(idle_cnt_reg);
    assign idle_tail = IDX_W'((tail_sum >= N_SUM) ? tail_sum - N_SUM : tail_sum);
    assign have_idle = (idle_cnt_reg != '0);

    // list contents without reset, except the idle queue
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_ISSUE:
            begin
                if (have_idle)
                    issued_list_reg[issued_cnt_reg[IDX_W-1:0]] <= idle_list_reg[idle_head_reg];
            end
            DP_RETIRE:
            begin
                if (!walk_end && !take)
                    write_list_reg[wr_idx] <= cur_s;
            end
            DP_WBACK:
            begin
                if (!walk_end)
                begin
                    if (take)
                        write_list_reg[write_cnt_reg[IDX_W-1:0]] <= cur_s;
                    else
                        exec_list_reg[wr_idx] <= cur_s;
                end
            end
            DP_DISPATCH:
            begin
                if (!walk_end)
                begin
                    if (take)
                        exec_list_reg[exec_cnt_reg[IDX_W-1:0]] <= cur_s;
                    else
                        issued_list_reg[wr_idx] <= cur_s;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_STATIONS; j++)
                idle_list_reg[j] <= IDX_W'(j);
        end
        else if (cmd.op == DP_RETIRE && !walk_end && take)
        begin
            idle_list_reg[idle_tail] <= cur_s;
        end
    end

    // word latch
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            op_reg    <= operation;
            ready_reg <= ready_mask;
            xdone_reg <= exec_done_mask;
            wdone_reg <= write_done_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_order_reg   <= 1'b0;
            units_reg      <= UNITS_W'(1);
            idle_head_reg  <= '0;
            idle_cnt_reg   <= CNT_W'(NUM_STATIONS);
            issued_cnt_reg <= '0;
            exec_cnt_reg   <= '0;
            write_cnt_reg  <= '0;
            walk_i_reg     <= '0;
            walk_k_reg     <= '0;
            stop_reg       <= 1'b0;
            done_reg       <= 1'b0;
            acc_reg        <= 1'b0;
            st_reg         <= '0;
            ret_reg        <= '0;
            sw_reg         <= '0;
            sx_reg         <= '0;
            unit_idle_reg  <= 1'b1;
        end
        else
        begin
            done_reg <= (cmd.op == DP_EMIT);

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IN_ORDER:   in_order_reg <= cfg_data[0];
                    CFG_EXEC_UNITS: units_reg    <= UNITS_W'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end

            case (cmd.op)
                DP_LOAD:
                begin
                    acc_reg    <= 1'b0;
                    st_reg     <= '0;
                    ret_reg    <= '0;
                    sw_reg     <= '0;
                    sx_reg     <= '0;
                    walk_i_reg <= '0;
                    walk_k_reg <= '0;
                    stop_reg   <= 1'b0;
                end
                DP_ISSUE:
                begin
                    if (have_idle)
                    begin
                        acc_reg        <= 1'b1;
                        st_reg         <= STA_W'(idle_list_reg[idle_head_reg]);
                        idle_head_reg  <= (idle_head_reg == LAST_IDX) ? '0 :
                                          idle_head_reg + IDX_W'(1);
                        idle_cnt_reg   <= idle_cnt_reg - CNT_W'(1);
                        issued_cnt_reg <= issued_cnt_reg + CNT_W'(1);
                    end
                end
                DP_EMIT:
                begin
                    unit_idle_reg <= (issued_cnt_reg == '0) && (exec_cnt_reg == '0) &&
                                     (write_cnt_reg == '0);
                end
                default:
                begin
                end
            endcase

            if (walking)
            begin
                if (walk_end)
                begin
                    // close the step: survivors form the new list
                    case (cmd.op)
                        DP_RETIRE: write_cnt_reg  <= walk_k_reg;
                        DP_WBACK:  exec_cnt_reg   <= walk_k_reg;
                        default:   issued_cnt_reg <= walk_k_reg;
                    endcase
                    walk_i_reg <= '0;
                    walk_k_reg <= '0;
                    stop_reg   <= 1'b0;
                end
                else
                begin
                    walk_i_reg <= walk_i_reg + CNT_W'(1);
                    if (take)
                    begin
                        case (cmd.op)
                            DP_RETIRE:
                            begin
                                idle_cnt_reg <= idle_cnt_reg + CNT_W'(1);
                                ret_reg      <= ret_reg | s_bit;
                            end
                            DP_WBACK:
                            begin
                                write_cnt_reg <= write_cnt_reg + CNT_W'(1);
                                sw_reg        <= sw_reg | s_bit;
                            end
                            default:
                            begin
                                exec_cnt_reg <= exec_cnt_reg + CNT_W'(1);
                                sx_reg       <= sx_reg | s_bit;
                            end
                        endcase
                    end
                    else
                    begin
                        walk_k_reg <= walk_k_reg + CNT_W'(1);
                        if (cmd.op != DP_RETIRE && in_order_reg)
                            stop_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign status.walk_end = walk_end;
    assign status.is_tick  = (op_reg == OP_TICK);

    assign done             = done_reg;
    assign issue_accepted   = acc_reg;
    assign issue_station    = st_reg;
    assign retired_mask     = ret_reg;
    assign start_write_mask = sw_reg;
    assign start_exec_mask  = sx_reg;
    assign unit_idle        = unit_idle_reg;

    // the four list counts add up to the pool size whenever no walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        !walking |-> ((32'(idle_cnt_reg) + 32'(issued_cnt_reg) + 32'(exec_cnt_reg) +
                       32'(write_cnt_reg)) == NUM_STATIONS))
        else $error("station counts do not add up to the pool size");

    // a result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    // an issue word never reports moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && acc_reg) |-> (ret_reg == '0 && sw_reg == '0 && sx_reg == '0))
        else $error("accepted issue carries move masks");

    // the walker never runs past the list it walks
    assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> (walk_k_reg <= walk_i_reg && walk_i_reg <= cur_n))
        else $error("list walker out of range");

endmodule

>>> design/reservation_station_scheduler_core.sv
// ----------------------------------------------------------------------------
// reservation_station_scheduler_core
// issue queue scheduler over a pool of reservation stations
// ----------------------------------------------------------------------------
// A word is taken on a clock edge with start high and busy low. For an issue
// word, the sequencer passes through its select, issue and emit states, and
// done is registered from the emit step. A tick word walks the writing,
// executing and issued lists one station per cycle, each step closed once the
// walk reaches the end of its list, and then emits. The list walker reads a
// single list entry per cycle. The result shows for one cycle with done high;
// the receiver cannot hold it off. busy drops in the cycle done is high, so
// the next word may be taken at the edge that ends it. Configuration writes
// are taken on any edge with cfg_write high and are meant for idle periods
// only.
// ----------------------------------------------------------------------------
module reservation_station_scheduler_core
    import rss_pkg::*;
#(
    parameter int NUM_STATIONS = DEF_NUM_STATIONS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [MASK_W-1:0]     ready_mask,
    input  logic [MASK_W-1:0]     exec_done_mask,
    input  logic [MASK_W-1:0]     write_done_mask,
    // result side
    output logic                  done,
    output logic                  issue_accepted,
    output logic [STA_W-1:0]      issue_station,
    output logic [MASK_W-1:0]     retired_mask,
    output logic [MASK_W-1:0]     start_write_mask,
    output logic [MASK_W-1:0]     start_exec_mask,
    output logic                  unit_idle
);

    // controller to datapath: one operation code per cycle
    dp_cmd_t    cmd;
    // datapath to controller: end of list walk, kind of word held
    dp_status_t status;

    // sequencer walks issue or the three tick steps in order
    rss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // lists, counts, configuration and result registers
    rss_datapath #(
        .NUM_STATIONS (NUM_STATIONS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .ready_mask       (ready_mask),
        .exec_done_mask   (exec_done_mask),
        .write_done_mask  (write_done_mask),
        .done             (done),
        .issue_accepted   (issue_accepted),
        .issue_station    (issue_station),
        .retired_mask     (retired_mask),
        .start_write_mask (start_write_mask),
        .start_exec_mask  (start_exec_mask),
        .unit_idle        (unit_idle)
    );

endmodule
